// ----- sv/tbsc_pkg.sv -----
// Shared types and constants for the tape block search controller.
`timescale 1ns / 1ps

package tbsc_pkg;

  // Input word kinds.
  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_BLOCK   = 2'd1,
    MODE_ERROR   = 2'd2,
    MODE_CLOSE   = 2'd3
  } mode_t;

  // Sequencer phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_FWD  = 2'd1,
    PH_REV  = 2'd2,
    PH_XFER = 2'd3
  } phase_t;

  // Tape commands.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_SFWD  = 3'd2,
    CMD_SREV  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WRITE = 3'd5
  } cmd_t;

  // Request completion codes.
  typedef enum logic [1:0] {
    CMP_PENDING = 2'd0,
    CMP_OK      = 2'd1,
    CMP_ERROR   = 2'd2,
    CMP_BUSY    = 2'd3
  } comp_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_LIMIT = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TURNAROUND  = 2'd2;

  localparam logic [9:0] BLOCK_LIMIT_RST = 10'd578;
  localparam logic [4:0] RETRY_LIMIT_RST = 5'd20;
  localparam logic [3:0] TURNAROUND_RST  = 4'd3;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic        select_error;
    logic        illegal_op;
    logic        block_missed;
    logic        end_zone;
    logic        up_to_speed;
    logic [17:0] mem_address;
    logic [14:0] word_count;
    logic        is_read;
    logic [9:0]  seen_block;
    logic [9:0]  target_block;
    logic [2:0]  drive;
    mode_t       mode;
  } item_t;

  typedef struct packed {
    logic        log_error;
    comp_t       completion;
    logic [14:0] dma_words;
    logic [17:0] dma_address;
    logic [2:0]  command_drive;
    logic        stop_first;
    cmd_t        command;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  retries_left;
    logic [2:0]  selected_drive;
    logic [2:0]  active_drive;
    logic [9:0]  wanted_block;
    logic        pending_read;
    logic [17:0] pending_address;
    logic [14:0] pending_words;
  } seq_state_t;

  typedef struct packed {
    logic [9:0] block_limit;
    logic [4:0] retry_limit;
    logic [3:0] turnaround_margin;
  } cfg_t;

endpackage

// ----- sv/tbsc_step.sv -----
// Next-state and result logic for one event of the block search sequencer.
`timescale 1ns / 1ps

module tbsc_step #(
  parameter int NUM_DRIVES = 8
) (
  input  tbsc_pkg::cfg_t          cfg,
  input  tbsc_pkg::seq_state_t    st,
  input  logic [NUM_DRIVES-1:0]   failed,
  input  tbsc_pkg::item_t         item,
  output tbsc_pkg::seq_state_t    st_nxt,
  output logic [NUM_DRIVES-1:0]   failed_nxt,
  output tbsc_pkg::result_t       res
);
  import tbsc_pkg::*;

  logic        busy;
  logic        drv_ok;
  logic        drv_failed;
  logic        req_start;
  logic        req_bad;
  logic        err_busy;
  logic        err_fatal;
  logic        err_exhaust;
  logic        err_retry;
  logic        blk_done;
  logic        finish;
  logic [10:0] rev_sum;

  always_comb begin
    drv_failed = 1'b0;
    for (int i = 0; i < NUM_DRIVES; i++) begin
      if (item.drive == 3'(i) && failed[i]) drv_failed = 1'b1;
    end
  end

  assign busy        = (st.phase != PH_IDLE);
  assign drv_ok      = ({1'b0, item.drive} < 4'(NUM_DRIVES));
  assign req_bad     = !drv_ok || (item.target_block >= cfg.block_limit) || drv_failed;
  assign req_start   = (item.mode == MODE_REQUEST) && !busy && !req_bad;
  assign err_busy    = (item.mode == MODE_ERROR) && busy;
  assign err_fatal   = err_busy && (item.illegal_op || item.select_error);
  assign err_exhaust = err_busy && !err_fatal && (st.retries_left <= 5'd1);
  assign err_retry   = err_busy && !err_fatal && !err_exhaust;
  assign blk_done    = (item.mode == MODE_BLOCK) && (st.phase == PH_XFER);
  assign finish      = blk_done || err_fatal || err_exhaust;
  // In reverse the search keeps going until it is the margin past the target.
  assign rev_sum     = {1'b0, item.seen_block} + {7'd0, cfg.turnaround_margin};

  // Phase transitions.
  always_comb begin
    st_nxt.phase = st.phase;
    if (finish) begin
      st_nxt.phase = PH_IDLE;
    end else if (req_start) begin
      st_nxt.phase = item.up_to_speed ? PH_FWD : PH_REV;
    end else if (item.mode == MODE_BLOCK) begin
      case (st.phase)
        PH_FWD: begin
          if (item.seen_block > st.wanted_block) st_nxt.phase = PH_REV;
          else if (item.seen_block == st.wanted_block) st_nxt.phase = PH_XFER;
        end
        PH_REV: begin
          if (rev_sum <= {1'b0, st.wanted_block}) st_nxt.phase = PH_FWD;
        end
        default: st_nxt.phase = st.phase;
      endcase
    end else if (err_retry) begin
      st_nxt.phase = (st.phase == PH_REV) ? PH_FWD : PH_REV;
    end
  end

  // Request bookkeeping and failed-drive flags.
  always_comb begin
    st_nxt.retries_left    = st.retries_left;
    st_nxt.selected_drive  = st.selected_drive;
    st_nxt.active_drive    = st.active_drive;
    st_nxt.wanted_block    = st.wanted_block;
    st_nxt.pending_read    = st.pending_read;
    st_nxt.pending_address = st.pending_address;
    st_nxt.pending_words   = st.pending_words;
    failed_nxt             = failed;
    if (req_start) begin
      st_nxt.retries_left    = cfg.retry_limit;
      st_nxt.selected_drive  = item.drive;
      st_nxt.active_drive    = item.drive;
      st_nxt.wanted_block    = item.target_block;
      st_nxt.pending_read    = item.is_read;
      st_nxt.pending_address = item.mem_address;
      st_nxt.pending_words   = item.word_count;
    end
    if (err_fatal || err_exhaust) st_nxt.retries_left = 5'd0;
    if (err_retry) st_nxt.retries_left = st.retries_left - 5'd1;
    for (int i = 0; i < NUM_DRIVES; i++) begin
      if (err_fatal && st.active_drive == 3'(i)) failed_nxt[i] = 1'b1;
      if (item.mode == MODE_CLOSE && item.drive == 3'(i)) failed_nxt[i] = 1'b0;
    end
  end

  // Result word.
  always_comb begin
    res               = '0;
    res.command       = CMD_NONE;
    res.completion    = CMP_PENDING;
    if (finish) begin
      res.command       = CMD_STOP;
      res.command_drive = st.active_drive;
      res.completion    = blk_done ? CMP_OK : CMP_ERROR;
    end else if (item.mode == MODE_REQUEST) begin
      if (busy) begin
        res.completion = CMP_BUSY;
      end else if (req_bad) begin
        res.completion = CMP_ERROR;
      end else begin
        res.stop_first    = (st.selected_drive != item.drive);
        res.command       = item.up_to_speed ? CMD_SFWD : CMD_SREV;
        res.command_drive = item.drive;
      end
    end else if (item.mode == MODE_BLOCK && busy) begin
      res.command_drive = st.active_drive;
      if (st.phase == PH_FWD) begin
        if (item.seen_block > st.wanted_block) begin
          res.command = CMD_SREV;
        end else if (item.seen_block < st.wanted_block) begin
          res.command = CMD_SFWD;
        end else begin
          res.command     = st.pending_read ? CMD_READ : CMD_WRITE;
          res.dma_address = st.pending_address;
          res.dma_words   = st.pending_words;
        end
      end else begin
        res.command = (rev_sum > {1'b0, st.wanted_block}) ? CMD_SREV : CMD_SFWD;
      end
    end else if (err_retry) begin
      res.command       = (st.phase == PH_REV) ? CMD_SFWD : CMD_SREV;
      res.command_drive = st.active_drive;
    end
    if (err_busy) res.log_error = !(item.end_zone || item.block_missed);
  end

endmodule

// ----- sv/tape_block_search_controller_core.sv -----
// Top level of the tape block search controller: ports, registers and handshake.
`timescale 1ns / 1ps

// Sequences one block transfer at a time on a set of tape drives.
// Input channel (in_*): one word per event; in_tuser gives its kind (request,
// block interrupt, error interrupt, drive close) and in_tdata its fields.
// Result channel (out_*): exactly one result word per input word, in order,
// carrying the tape command, its drive, the DMA buffer of a data command, the
// completion code and an error-log flag.
// Configuration channel (cfg_*): writes block_limit, retry_limit and
// turnaround_margin by index; always ready, meant to be used while idle.
// An accepted word is held in the input register, and its result is loaded
// into the output register once that register is empty or being drained,
// which raises out_tvalid. Throughput is one word per cycle while out_tready
// stays high, set by the single pass of compare logic between the input and
// output registers.
// When the receiver stalls, the result is held and one more word can wait in
// the input register; after that in_tready drops until out_tready returns.
// Reset (rst_n low, synchronous) empties both registers, makes the sequencer
// idle, clears all failed-drive flags and restores the register defaults.
module tape_block_search_controller_core #(
  parameter int NUM_DRIVES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: drive, target_block, seen_block, is_read, word_count,
  // mem_address, up_to_speed, end_zone, block_missed, illegal_op,
  // select_error, zero fill.
  input  logic [tbsc_pkg::IN_DATA_W-1:0]     in_tdata,
  // Fields from bit 0: mode.
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: command, stop_first, command_drive, dma_address,
  // dma_words, completion, log_error, zero fill.
  output logic [tbsc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [9:0]                         cfg_data
);
  import tbsc_pkg::*;

  cfg_t                  cfg_r;
  seq_state_t            state_r;
  seq_state_t            state_nxt;
  logic [NUM_DRIVES-1:0] failed_r;
  logic [NUM_DRIVES-1:0] failed_nxt;
  logic                  in_valid_r;
  item_t                 item_r;
  logic                  out_valid_r;
  result_t               res_r;
  result_t               res;
  logic                  adv;

  // A word moves from the input register to the output register when the
  // output register is empty or being drained.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  tbsc_step #(
    .NUM_DRIVES(NUM_DRIVES)
  ) u_step (
    .cfg        (cfg_r),
    .st         (state_r),
    .failed     (failed_r),
    .item       (item_r),
    .st_nxt     (state_nxt),
    .failed_nxt (failed_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_limit       <= BLOCK_LIMIT_RST;
      cfg_r.retry_limit       <= RETRY_LIMIT_RST;
      cfg_r.turnaround_margin <= TURNAROUND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCK_LIMIT: cfg_r.block_limit       <= cfg_data;
        CFG_RETRY_LIMIT: cfg_r.retry_limit       <= cfg_data[4:0];
        CFG_TURNAROUND:  cfg_r.turnaround_margin <= cfg_data[3:0];
        default:         cfg_r                   <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      failed_r    <= '0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
        failed_r    <= failed_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) item_r <= item_t'({in_tdata[61:0], in_tuser});
    if (adv) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r};

  // A rejected request leaves the sequencer phase alone.
  a_busy_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.completion == CMP_BUSY |=> $stable(state_r.phase))
    else $error("busy rejection changed the phase");

  // A stop always ends the request.
  a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.command == CMD_STOP |=> state_r.phase == PH_IDLE)
    else $error("stop issued without going idle");

  // A data command puts the sequencer in the transfer phase.
  a_data_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (res.command == CMD_READ || res.command == CMD_WRITE)
    |=> state_r.phase == PH_XFER)
    else $error("data command without transfer phase");

  // An empty output register never blocks the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule

// ----- tb/sv/tape_block_search_controller_core_tb.sv -----
// Self-checking testbench for the tape block search controller core.
`timescale 1ns / 1ps

module tape_block_search_controller_core_tb;
  import tbsc_pkg::*;

  localparam int MAX_SHOWN = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // Fields from bit 0: drive, target_block, seen_block, is_read, word_count,
  // mem_address, up_to_speed, end_zone, block_missed, illegal_op,
  // select_error, zero fill.
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // Fields from bit 0: mode.
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // Fields from bit 0: command, stop_first, command_drive, dma_address,
  // dma_words, completion, log_error, zero fill.
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [9:0]            cfg_data = '0;

  tape_block_search_controller_core #(
    .NUM_DRIVES(8)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted sequencer state and register copies.
  logic [9:0]  blk_limit = BLOCK_LIMIT_RST;
  logic [4:0]  rty_limit = RETRY_LIMIT_RST;
  logic [3:0]  margin = TURNAROUND_RST;
  phase_t      seq_phase = PH_IDLE;
  logic [4:0]  retries = '0;
  logic [7:0]  failed_drives = '0;
  logic [2:0]  sel_drive = '0;
  logic [2:0]  act_drive = '0;
  logic [9:0]  wanted = '0;
  logic        want_read = 1'b0;
  logic [17:0] buf_addr = '0;
  logic [14:0] buf_words = '0;

  result_t     predicted_replies[$];
  bit          no_idle = 1'b0;
  int          tape_pos = 0;
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_done_ok = 0;
  int          n_aborted = 0;
  int          n_started = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tape_block_search_controller_core_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= 34);
  end

  // Computes the tape command word that one event causes and advances the state.
  task automatic next_tape_command(input item_t it, output result_t r);
    bit fin;
    r = '0;
    fin = 1'b0;
    case (it.mode)
      MODE_REQUEST: begin
        if (seq_phase != PH_IDLE) begin
          r.completion = CMP_BUSY;
        end else if (it.target_block >= blk_limit || failed_drives[it.drive]) begin
          r.completion = CMP_ERROR;
        end else begin
          r.stop_first = (sel_drive != it.drive);
          sel_drive = it.drive;
          act_drive = it.drive;
          wanted = it.target_block;
          want_read = it.is_read;
          buf_addr = it.mem_address;
          buf_words = it.word_count;
          retries = rty_limit;
          if (it.up_to_speed) begin
            seq_phase = PH_FWD;
            r.command = CMD_SFWD;
          end else begin
            seq_phase = PH_REV;
            r.command = CMD_SREV;
          end
          r.command_drive = it.drive;
        end
      end
      MODE_BLOCK: begin
        case (seq_phase)
          PH_XFER: begin
            fin = 1'b1;
            r.completion = CMP_OK;
          end
          PH_FWD: begin
            if (it.seen_block > wanted) begin
              seq_phase = PH_REV;
              r.command = CMD_SREV;
            end else if (it.seen_block < wanted) begin
              r.command = CMD_SFWD;
            end else begin
              seq_phase = PH_XFER;
              r.command = want_read ? CMD_READ : CMD_WRITE;
              r.dma_address = buf_addr;
              r.dma_words = buf_words;
            end
            r.command_drive = act_drive;
          end
          PH_REV: begin
            // The overshoot sum is compared without wrapping.
            if (int'(it.seen_block) + int'(margin) > int'(wanted)) begin
              r.command = CMD_SREV;
            end else begin
              seq_phase = PH_FWD;
              r.command = CMD_SFWD;
            end
            r.command_drive = act_drive;
          end
          default: ;
        endcase
      end
      MODE_ERROR: begin
        if (seq_phase != PH_IDLE) begin
          r.log_error = !(it.end_zone || it.block_missed);
          if (it.illegal_op || it.select_error) begin
            failed_drives[act_drive] = 1'b1;
            retries = '0;
            fin = 1'b1;
            r.completion = CMP_ERROR;
          end else if (retries <= 5'd1) begin
            retries = '0;
            fin = 1'b1;
            r.completion = CMP_ERROR;
          end else begin
            retries = retries - 5'd1;
            if (seq_phase == PH_REV) begin
              seq_phase = PH_FWD;
              r.command = CMD_SFWD;
            end else begin
              seq_phase = PH_REV;
              r.command = CMD_SREV;
            end
            r.command_drive = act_drive;
          end
        end
      end
      default: failed_drives[it.drive] = 1'b0;
    endcase
    if (fin) begin
      seq_phase = PH_IDLE;
      r.command = CMD_STOP;
      r.command_drive = act_drive;
    end
  endtask

  // Sends one event word; the prediction is taken at the accepting edge.
  task automatic send_word(input item_t it);
    result_t r;
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'(it >> 2);
    in_tuser <= it.mode;
    do @(posedge clk); while (!in_tready);
    next_tape_command(it, r);
    predicted_replies.push_back(r);
    n_sent++;
    if (it.mode == MODE_REQUEST && r.command != CMD_NONE) n_started++;
  endtask

  task automatic check_word(input logic [OUT_DATA_W-1:0] raw);
    result_t got;
    result_t want;
    bit bad;
    got = result_t'(raw[42:0]);
    if (predicted_replies.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_SHOWN) $display("unexpected result word %h", raw);
    end else begin
      want = predicted_replies.pop_front();
      n_checked++;
      if (want.completion == CMP_OK) n_done_ok++;
      if (want.completion == CMP_ERROR && want.command == CMD_STOP) n_aborted++;
      bad = (got.command !== want.command) || (got.stop_first !== want.stop_first) ||
            (got.command_drive !== want.command_drive) ||
            (got.dma_address !== want.dma_address) || (got.dma_words !== want.dma_words) ||
            (got.completion !== want.completion) || (got.log_error !== want.log_error) ||
            (raw[OUT_DATA_W-1:43] !== '0);
      if (bad) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN) begin
          $display("result %0d mismatch: expected cmd=%0d stop=%0d drv=%0d addr=%h words=%h",
                   n_checked, want.command, want.stop_first, want.command_drive,
                   want.dma_address, want.dma_words);
          $display("  comp=%0d log=%0d, actual cmd=%0d stop=%0d drv=%0d addr=%h words=%h",
                   want.completion, want.log_error, got.command, got.stop_first,
                   got.command_drive, got.dma_address, got.dma_words);
          $display("  comp=%0d log=%0d fill=%h", got.completion, got.log_error,
                   raw[OUT_DATA_W-1:43]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_word(out_tdata);
  end

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BLOCK_LIMIT: blk_limit = val;
      CFG_RETRY_LIMIT: rty_limit = val[4:0];
      CFG_TURNAROUND:  margin = val[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int bl, input int rl, input int tm);
    drain_results();
    write_reg(CFG_BLOCK_LIMIT, 10'(bl));
    write_reg(CFG_RETRY_LIMIT, 10'(rl));
    write_reg(CFG_TURNAROUND, 10'(tm));
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t rand_item(input mode_t m);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.mode = m;
    return it;
  endfunction

  task automatic send_request(input int drv, input int target, input bit ups, input bit rd);
    item_t it;
    it = rand_item(MODE_REQUEST);
    it.drive = 3'(drv);
    it.target_block = 10'(target);
    it.up_to_speed = ups;
    it.is_read = rd;
    send_word(it);
  endtask

  task automatic send_block(input int seen);
    item_t it;
    it = rand_item(MODE_BLOCK);
    it.seen_block = 10'(seen);
    send_word(it);
  endtask

  // Flags from bit 0: end_zone, block_missed, illegal_op, select_error.
  task automatic send_error(input logic [3:0] flags);
    item_t it;
    it = rand_item(MODE_ERROR);
    {it.select_error, it.illegal_op, it.block_missed, it.end_zone} = flags;
    send_word(it);
  endtask

  task automatic send_close(input int drv);
    item_t it;
    it = rand_item(MODE_CLOSE);
    it.drive = 3'(drv);
    send_word(it);
  endtask

  // Idle interrupts, a full forward read, a reverse search with turnaround,
  // busy rejection and error recovery.
  task automatic test_basic_sequences();
    item_t it;
    send_block(0);
    send_error(4'b0000);
    send_request(0, 5, 1'b1, 1'b1);
    send_block(3);
    send_block(5);
    send_block(9);
    send_request(7, 1023, 1'b1, 1'b1);
    send_request(7, 577, 1'b0, 1'b0);
    send_request(2, 1, 1'b1, 1'b1);
    send_block(577);
    send_block(574);
    send_error(4'b0001);
    send_error(4'b0000);
    send_error(4'b0100);
    send_request(7, 10, 1'b1, 1'b1);
    send_close(7);
    it = rand_item(MODE_REQUEST);
    it.drive = 3'd7;
    it.target_block = '0;
    it.up_to_speed = 1'b1;
    it.is_read = 1'b0;
    it.word_count = '1;
    it.mem_address = '1;
    send_word(it);
    send_block(0);
    send_error(4'b0010);
    send_block(0);
    send_error(4'b1000);
    send_close(7);
  endtask

  // Register extremes: no legal block, single retry, largest overshoot.
  task automatic test_config_extremes();
    apply_settings(0, 1, 0);
    send_request(1, 0, 1'b1, 1'b1);
    apply_settings(1023, 1, 15);
    send_request(1, 1022, 1'b1, 1'b1);
    send_error(4'b0011);
    send_request(0, 1022, 1'b0, 1'b0);
    send_block(1008);
    send_block(1007);
    send_block(1022);
    send_block(0);
    apply_settings(1023, 2, 0);
    send_request(3, 0, 1'b0, 1'b1);
    send_block(0);
    send_error(4'b0001);
    send_error(4'b0010);
  endtask

  // Mostly well-formed request sequences against a simulated tape position.
  task automatic test_random_traffic(input int n_items, input bit pause_midway);
    item_t it;
    int done;
    int pick;
    bit ignored;
    done = 0;
    while (done < n_items) begin
      if (pause_midway && done == n_items / 2) begin
        drain_results();
        pause_midway = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (seq_phase == PH_IDLE) begin
        if (pick < 80) begin
          it = rand_item(MODE_REQUEST);
          if (blk_limit != 0 && $urandom_range(0, 9) != 0)
            it.target_block = 10'($urandom_range(0, int'(blk_limit) - 1));
          tape_pos = int'(it.target_block) + $urandom_range(0, 24) - 12;
          if (tape_pos < 0) tape_pos = 0;
          if (tape_pos > 1023) tape_pos = 1023;
        end else if (pick < 92) begin
          it = rand_item(MODE_CLOSE);
        end else begin
          it = rand_item(pick < 96 ? MODE_BLOCK : MODE_ERROR);
        end
      end else if (pick < 78) begin
        it = rand_item(MODE_BLOCK);
        if ($urandom_range(0, 9) != 0) begin
          if (seq_phase == PH_FWD && tape_pos < 1023) tape_pos++;
          if (seq_phase == PH_REV && tape_pos > 0) tape_pos--;
          it.seen_block = 10'(tape_pos);
        end
      end else if (pick < 88) begin
        it = rand_item(MODE_ERROR);
        it.illegal_op = ($urandom_range(0, 9) == 0);
        it.select_error = ($urandom_range(0, 9) == 0);
      end else if (pick < 94) begin
        it = rand_item(MODE_REQUEST);
      end else begin
        it = rand_item(MODE_CLOSE);
      end
      ignored = (seq_phase == PH_IDLE) &&
                (it.mode == MODE_BLOCK || it.mode == MODE_ERROR);
      send_word(it);
      if (!ignored) done++;
    end
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_sequences();
    test_config_extremes();
    apply_settings(1023, 31, 15);
    test_random_traffic(300, 1'b0);
    drain_results();
    no_idle = 1'b1;
    apply_settings(578, 20, 3);
    test_random_traffic(300, 1'b0);
    drain_results();
    no_idle = 1'b0;
    apply_settings(40, 1, 0);
    test_random_traffic(300, 1'b1);
    apply_settings($urandom_range(1, 1023), $urandom_range(1, 31), $urandom_range(0, 15));
    test_random_traffic(300, 1'b0);
    in_tvalid <= 1'b0;
    guard = 0;
    while (predicted_replies.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      $display("%0d result words never arrived", predicted_replies.size());
      n_errors += predicted_replies.size();
    end
    $display("Sent %0d event words over eight register settings; checked %0d results.",
             n_sent, n_checked);
    $display("Requests started %0d, transfers finished %0d, requests aborted %0d.",
             n_started, n_done_ok, n_aborted);
    if (n_errors == 0) begin
      $display("tape_block_search_controller_core_tb: done, clean");
    end else begin
      $display("tape_block_search_controller_core_tb: done, errors");
    end
    $finish;
  end

endmodule
